// ----- rtl/core/utc_to_civil_time_macros.svh -----
// ----------------------------------------------------------------------------
// utc_to_civil_time assertion macros
// Concurrent assertion helpers used by the top level of the converter.
// ----------------------------------------------------------------------------
`ifndef UTC_TO_CIVIL_TIME_MACROS_SVH
`define UTC_TO_CIVIL_TIME_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define UTC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define UTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define UTC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define UTC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/utc_pkg.sv -----
// ----------------------------------------------------------------------------
// utc_pkg
// Widths, pipeline stage map, reciprocal constants and month tables for the
// seconds-to-calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package utc_pkg;

  // pipeline stage map
  localparam int STAGES   = 8;
  localparam int ST_IN    = 0;   // input register
  localparam int ST_DAYS  = 1;   // day count
  localparam int ST_SPLIT = 2;   // second of day, day of era
  localparam int ST_DIV   = 3;   // reciprocal divides
  localparam int ST_NUM   = 4;   // year-of-era numerator, min/sec
  localparam int ST_YOE   = 5;   // year of era
  localparam int ST_DOY   = 6;   // day of year
  localparam int ST_OUT   = 7;   // result register

  // field widths
  localparam int SEC_W    = 32;
  localparam int DAYS_W   = 16;
  localparam int SOD_W    = 17;
  localparam int DOE_W    = 18;
  localparam int YOE_W    = 9;
  localparam int DOY_W    = 9;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SECM_W   = 6;
  localparam int Q60_W    = 11;
  localparam int Q1460_W  = 7;
  localparam int CENT_W   = 3;
  localparam int OUT_PAD_W = 2;
  localparam int OUT_W    = 40;

  // seconds per day = 128 * 675; t[31:7] / 675 by reciprocal
  localparam int DAY_PRE_SHIFT = 7;
  localparam int DAY_PROD_W    = 51;
  localparam int DAY_SHIFT     = 35;
  localparam logic [DAY_PROD_W-1:0] DAY_RECIP = 51'd50903317;
  localparam logic [SEC_W-1:0] SECS_PER_DAY = 32'd86400;

  // second of day / 60 and / 3600
  localparam int Q60_PROD_W = 35;
  localparam int Q60_SHIFT  = 23;
  localparam logic [Q60_PROD_W-1:0] Q60_RECIP = 35'd139811;
  localparam int HR_PROD_W  = 34;
  localparam int HR_SHIFT   = 28;
  localparam logic [HR_PROD_W-1:0] HR_RECIP = 34'd74566;
  localparam int SEC_PER_MIN = 60;

  // day of era / 1460 and numerator / 365
  localparam int Q1460_PROD_W = 34;
  localparam int Q1460_SHIFT  = 26;
  localparam logic [Q1460_PROD_W-1:0] Q1460_RECIP = 34'd45965;
  localparam int YOE_PROD_W = 36;
  localparam int YOE_SHIFT  = 26;
  localparam logic [YOE_PROD_W-1:0] YOE_RECIP = 36'd183860;

  // era selection: all inputs fall in era 4 or era 5 of the March-based epoch
  localparam logic [DAYS_W-1:0] ERA5_FIRST_DAY = 16'd11017;
  localparam logic [DOE_W-1:0]  ERA4_DOE_OFS   = 18'd135080;
  localparam logic [YEAR_W-1:0] ERA4_BASE_YEAR = 12'd1600;
  localparam logic [YEAR_W-1:0] ERA5_BASE_YEAR = 12'd2000;

  // century boundaries inside an era
  localparam logic [DOE_W-1:0] DOE_C1   = 18'd36524;
  localparam logic [DOE_W-1:0] DOE_C2   = 18'd73048;
  localparam logic [DOE_W-1:0] DOE_C3   = 18'd109572;
  localparam logic [DOE_W-1:0] DOE_LAST = 18'd146096;
  localparam logic [YOE_W-1:0] YOE_C1   = 9'd100;
  localparam logic [YOE_W-1:0] YOE_C2   = 9'd200;
  localparam logic [YOE_W-1:0] YOE_C3   = 9'd300;
  localparam logic [DOE_W-1:0] DAYS_PER_YEAR = 18'd365;

  // month counted from March
  localparam int MONTH_COUNT = 12;
  localparam logic [MONTH_W-1:0] JAN_MP     = 4'd10;
  localparam logic [MONTH_W-1:0] MARCH_NUM  = 4'd3;

  typedef struct packed {
    logic [STAGES-1:0] ld;
    logic [STAGES-1:0] vld;
  } pipe_ctl_t;

  typedef struct packed {
    logic              ok;
    logic              era5;
    logic [DOE_W-1:0]  doe;
    logic [SOD_W-1:0]  sod;
  } day_split_t;

  typedef struct packed {
    logic              ok;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SECM_W-1:0] second;
  } tod_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // result word layout, year in the low bits
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [SECM_W-1:0]    second;
    logic [MIN_W-1:0]     minute;
    logic [HOUR_W-1:0]    hour;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
  } out_word_t;

  // first day of year for each March-based month
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // March-based month index: count of month starts at or below day of year
  function automatic logic [MONTH_W-1:0] month_index(input logic [DOY_W-1:0] doy);
    logic [MONTH_W-1:0] cnt;
    cnt = '0;
    for (int k = 1; k < MONTH_COUNT; k++) begin
      if (doy >= month_start(MONTH_W'(k))) begin
        cnt = cnt + 4'd1;
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/utc_ctl.sv -----
// ----------------------------------------------------------------------------
// utc_ctl
// Stage valid bits and per-stage load enables for the converter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_ctl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_valid,
  input  wire logic              m_ready,
  output utc_pkg::pipe_ctl_t     ctl
);

  logic [utc_pkg::STAGES-1:0] vld;
  logic [utc_pkg::STAGES-1:0] vld_next;
  logic [utc_pkg::STAGES-1:0] ld;

  // a stage loads when empty or when the stage after it moves
  assign ld[utc_pkg::ST_OUT] = !vld[utc_pkg::ST_OUT] || m_ready;
  for (genvar i = 0; i < utc_pkg::STAGES - 1; i++) begin : g_ld
    assign ld[i] = !vld[i] || ld[i+1];
  end

  // valid bits follow the data
  always_comb begin
    vld_next[0] = ld[0] ? s_valid : vld[0];
    for (int i = 1; i < utc_pkg::STAGES; i++) begin
      vld_next[i] = ld[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign ctl.ld  = ld;
  assign ctl.vld = vld;

endmodule

`default_nettype wire

// ----- rtl/core/utc_day_split.sv -----
// ----------------------------------------------------------------------------
// utc_day_split
// Input register, day count by reciprocal multiply, then second of day and
// day of the 400-year era.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_day_split (
  input  wire logic                        clk,
  input  wire utc_pkg::pipe_ctl_t          ctl,
  input  wire logic [utc_pkg::SEC_W-1:0]   in_seconds,
  input  wire logic [utc_pkg::SEC_W-1:0]   threshold,
  output utc_pkg::day_split_t              split
);

  logic [utc_pkg::SEC_W-1:0]      t0;
  logic                           ok0;
  logic [utc_pkg::SEC_W-1:0]      t1;
  logic                           ok1;
  logic [utc_pkg::DAYS_W-1:0]     days1;
  logic [utc_pkg::DAY_PROD_W-1:0] day_prod;
  logic [utc_pkg::SEC_W-1:0]      day_base;
  logic [utc_pkg::SEC_W-1:0]      sod_full;
  logic                           era5;
  logic [utc_pkg::DOE_W-1:0]      doe;
  utc_pkg::day_split_t            split2;

  // input register with threshold compare
  always_ff @(posedge clk) begin
    if (ctl.ld[utc_pkg::ST_IN]) begin
      t0  <= in_seconds;
      ok0 <= (in_seconds >= threshold);
    end
  end

  // days = (t >> 7) / 675
  assign day_prod = utc_pkg::DAY_PROD_W'(t0[utc_pkg::SEC_W-1:utc_pkg::DAY_PRE_SHIFT])
                  * utc_pkg::DAY_RECIP;

  always_ff @(posedge clk) begin
    if (ctl.ld[utc_pkg::ST_DAYS]) begin
      t1    <= t0;
      ok1   <= ok0;
      days1 <= day_prod[utc_pkg::DAY_SHIFT +: utc_pkg::DAYS_W];
    end
  end

  // second of day and day of era
  assign day_base = utc_pkg::SEC_W'(days1) * utc_pkg::SECS_PER_DAY;
  assign sod_full = t1 - day_base;
  assign era5     = (days1 >= utc_pkg::ERA5_FIRST_DAY);
  assign doe      = era5 ?
                    utc_pkg::DOE_W'(days1) - utc_pkg::DOE_W'(utc_pkg::ERA5_FIRST_DAY) :
                    utc_pkg::DOE_W'(days1) + utc_pkg::ERA4_DOE_OFS;

  always_ff @(posedge clk) begin
    if (ctl.ld[utc_pkg::ST_SPLIT]) begin
      split2.ok   <= ok1;
      split2.era5 <= era5;
      split2.doe  <= doe;
      split2.sod  <= sod_full[utc_pkg::SOD_W-1:0];
    end
  end

  assign split = split2;

endmodule

`default_nettype wire

// ----- rtl/core/utc_tod.sv -----
// ----------------------------------------------------------------------------
// utc_tod
// Hour, minute and second from the second of day, delayed to line up with
// the date path.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_tod (
  input  wire logic                  clk,
  input  wire utc_pkg::pipe_ctl_t    ctl,
  input  wire utc_pkg::day_split_t   split,
  output utc_pkg::tod_t              tod
);

  logic [utc_pkg::Q60_PROD_W-1:0] q60_prod;
  logic [utc_pkg::HR_PROD_W-1:0]  hr_prod;
  logic                           ok3;
  logic [utc_pkg::SOD_W-1:0]      sod3;
  logic [utc_pkg::Q60_W-1:0]      q60_3;
  logic [utc_pkg::HOUR_W-1:0]     hr3;
  logic [utc_pkg::Q60_W-1:0]      min_full;
  logic [utc_pkg::SOD_W-1:0]      sec_full;
  utc_pkg::tod_t                  tod4;
  utc_pkg::tod_t                  tod5;
  utc_pkg::tod_t                  tod6;

  // sod / 60 and sod / 3600 side by side
  assign q60_prod = utc_pkg::Q60_PROD_W'(split.sod) * utc_pkg::Q60_RECIP;
  assign hr_prod  = utc_pkg::HR_PROD_W'(split.sod) * utc_pkg::HR_RECIP;

  always_ff @(posedge clk) begin
    if (ctl.ld[utc_pkg::ST_DIV]) begin
      ok3   <= split.ok;
      sod3  <= split.sod;
      q60_3 <= q60_prod[utc_pkg::Q60_SHIFT +: utc_pkg::Q60_W];
      hr3   <= hr_prod[utc_pkg::HR_SHIFT +: utc_pkg::HOUR_W];
    end
  end

  // remainders
  assign min_full = q60_3 - utc_pkg::Q60_W'(hr3) * utc_pkg::Q60_W'(utc_pkg::SEC_PER_MIN);
  assign sec_full = sod3 - utc_pkg::SOD_W'(q60_3) * utc_pkg::SOD_W'(utc_pkg::SEC_PER_MIN);

  always_ff @(posedge clk) begin
    if (ctl.ld[utc_pkg::ST_NUM]) begin
      tod4.ok     <= ok3;
      tod4.hour   <= hr3;
      tod4.minute <= min_full[utc_pkg::MIN_W-1:0];
      tod4.second <= sec_full[utc_pkg::SECM_W-1:0];
    end
  end

  // delay line to the date path
  always_ff @(posedge clk) begin
    if (ctl.ld[utc_pkg::ST_YOE]) begin
      tod5 <= tod4;
    end
    if (ctl.ld[utc_pkg::ST_DOY]) begin
      tod6 <= tod5;
    end
  end

  assign tod = tod6;

endmodule

`default_nettype wire

// ----- rtl/core/utc_date.sv -----
// ----------------------------------------------------------------------------
// utc_date
// Year of era, day of year and March-based month from the day of era,
// then the calendar year, month and day.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_date (
  input  wire logic                  clk,
  input  wire utc_pkg::pipe_ctl_t    ctl,
  input  wire utc_pkg::day_split_t   split,
  output utc_pkg::date_t             date
);

  logic [utc_pkg::Q1460_PROD_W-1:0] q1460_prod;
  logic [utc_pkg::CENT_W-1:0]       cent;
  logic [utc_pkg::DOE_W-1:0]        doe3;
  logic                             era3;
  logic [utc_pkg::Q1460_W-1:0]      q1460_3;
  logic [utc_pkg::CENT_W-1:0]       cent3;
  logic                             last3;
  logic [utc_pkg::DOE_W-1:0]        doe4;
  logic                             era4;
  logic [utc_pkg::DOE_W-1:0]        num4;
  logic [utc_pkg::YOE_PROD_W-1:0]   yoe_prod;
  logic [utc_pkg::DOE_W-1:0]        doe5;
  logic                             era5;
  logic [utc_pkg::YOE_W-1:0]        yoe5;
  logic [utc_pkg::CENT_W-1:0]       ycent;
  logic [utc_pkg::DOE_W-1:0]        year_days;
  logic [utc_pkg::DOE_W-1:0]        doy_full;
  logic                             era6;
  logic [utc_pkg::YOE_W-1:0]        yoe6;
  logic [utc_pkg::DOY_W-1:0]        doy6;
  logic [utc_pkg::MONTH_W-1:0]      mp;
  logic [utc_pkg::DOY_W-1:0]        day_full;

  // doe / 1460 and the century count
  assign q1460_prod = utc_pkg::Q1460_PROD_W'(split.doe) * utc_pkg::Q1460_RECIP;
  assign cent = utc_pkg::CENT_W'(split.doe >= utc_pkg::DOE_C1)
              + utc_pkg::CENT_W'(split.doe >= utc_pkg::DOE_C2)
              + utc_pkg::CENT_W'(split.doe >= utc_pkg::DOE_C3)
              + utc_pkg::CENT_W'(split.doe >= utc_pkg::DOE_LAST);

  always_ff @(posedge clk) begin
    if (ctl.ld[utc_pkg::ST_DIV]) begin
      doe3    <= split.doe;
      era3    <= split.era5;
      q1460_3 <= q1460_prod[utc_pkg::Q1460_SHIFT +: utc_pkg::Q1460_W];
      cent3   <= cent;
      last3   <= (split.doe == utc_pkg::DOE_LAST);
    end
  end

  // leap-corrected numerator for the year of era
  always_ff @(posedge clk) begin
    if (ctl.ld[utc_pkg::ST_NUM]) begin
      doe4 <= doe3;
      era4 <= era3;
      num4 <= doe3 - utc_pkg::DOE_W'(q1460_3) + utc_pkg::DOE_W'(cent3)
            - utc_pkg::DOE_W'(last3);
    end
  end

  // year of era = num / 365
  assign yoe_prod = utc_pkg::YOE_PROD_W'(num4) * utc_pkg::YOE_RECIP;

  always_ff @(posedge clk) begin
    if (ctl.ld[utc_pkg::ST_YOE]) begin
      doe5 <= doe4;
      era5 <= era4;
      yoe5 <= yoe_prod[utc_pkg::YOE_SHIFT +: utc_pkg::YOE_W];
    end
  end

  // day of year
  assign ycent = utc_pkg::CENT_W'(yoe5 >= utc_pkg::YOE_C1)
               + utc_pkg::CENT_W'(yoe5 >= utc_pkg::YOE_C2)
               + utc_pkg::CENT_W'(yoe5 >= utc_pkg::YOE_C3);
  assign year_days = utc_pkg::DOE_W'(yoe5) * utc_pkg::DAYS_PER_YEAR
                   + utc_pkg::DOE_W'(yoe5[utc_pkg::YOE_W-1:2])
                   - utc_pkg::DOE_W'(ycent);
  assign doy_full = doe5 - year_days;

  always_ff @(posedge clk) begin
    if (ctl.ld[utc_pkg::ST_DOY]) begin
      era6 <= era5;
      yoe6 <= yoe5;
      doy6 <= doy_full[utc_pkg::DOY_W-1:0];
    end
  end

  // month from March, day, and year with January and February moved forward
  assign mp       = utc_pkg::month_index(doy6);
  assign day_full = doy6 - utc_pkg::month_start(mp) + 9'd1;

  always_comb begin
    date.month = (mp < utc_pkg::JAN_MP) ? mp + utc_pkg::MARCH_NUM :
                                          mp - utc_pkg::JAN_MP + 4'd1;
    date.day   = day_full[utc_pkg::DAY_W-1:0];
    date.year  = utc_pkg::YEAR_W'(yoe6)
               + (era6 ? utc_pkg::ERA5_BASE_YEAR : utc_pkg::ERA4_BASE_YEAR)
               + utc_pkg::YEAR_W'(mp >= utc_pkg::JAN_MP);
  end

endmodule

`default_nettype wire

// ----- rtl/core/utc_to_civil_time.sv -----
// ----------------------------------------------------------------------------
// utc_to_civil_time: 32-bit seconds since 1970 to calendar date and time.
// Throughput: one word per cycle through an eight-stage pipeline; a full
// pipeline stalls only while the result word waits, any empty stage lets a
// new word in.
// Reset clears all stage valid bits and sets the threshold to 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utc_to_civil_time_macros.svh"

module utc_to_civil_time (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] utc_seconds
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [11:0] year, [15:12] month,
                                           // [20:16] day_of_month, [25:21] hour,
                                           // [31:26] minute, [37:32] second_of_minute,
                                           // [39:38] zero
  output logic             m_axis_tuser,   // [0] clock_valid
  // threshold write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  utc_pkg::pipe_ctl_t         ctl;
  utc_pkg::day_split_t        split;
  utc_pkg::tod_t              tod;
  utc_pkg::date_t             date;
  logic [utc_pkg::SEC_W-1:0]  valid_from_seconds;
  utc_pkg::out_word_t         out_word;
  logic                       out_ok;
  logic                       out_in_range;

  // threshold register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_from_seconds <= '0;
    end else if (cfg_valid) begin
      valid_from_seconds <= cfg_data;
    end
  end

  // pipeline control
  utc_ctl u_ctl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .m_ready (m_axis_tready),
    .ctl     (ctl)
  );

  utc_day_split u_day_split (
    .clk        (clk),
    .ctl        (ctl),
    .in_seconds (s_axis_tdata),
    .threshold  (valid_from_seconds),
    .split      (split)
  );

  utc_tod u_tod (
    .clk   (clk),
    .ctl   (ctl),
    .split (split),
    .tod   (tod)
  );

  utc_date u_date (
    .clk   (clk),
    .ctl   (ctl),
    .split (split),
    .date  (date)
  );

  // result register, all fields zero when the clock is unset
  always_ff @(posedge clk) begin
    if (ctl.ld[utc_pkg::ST_OUT]) begin
      out_ok <= tod.ok;
      if (tod.ok) begin
        out_word.pad    <= '0;
        out_word.second <= tod.second;
        out_word.minute <= tod.minute;
        out_word.hour   <= tod.hour;
        out_word.day    <= date.day;
        out_word.month  <= date.month;
        out_word.year   <= date.year;
      end else begin
        out_word <= '0;
      end
    end
  end

  assign s_axis_tready = ctl.ld[utc_pkg::ST_IN];
  assign m_axis_tvalid = ctl.vld[utc_pkg::ST_OUT];
  assign m_axis_tdata  = out_word;
  assign m_axis_tuser  = out_ok;

  // calendar range of the result fields
  assign out_in_range = (out_word.month >= 4'd1) && (out_word.month <= 4'd12) &&
                        (out_word.day >= 5'd1) && (out_word.hour <= 5'd23) &&
                        (out_word.minute <= 6'd59) && (out_word.second <= 6'd59) &&
                        (out_word.year >= 12'd1970);

  // unset clock gives an all-zero word
  `UTC_ASSERT_IMPLIES(a_unset_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
  // a set clock gives fields in calendar range
  `UTC_ASSERT_IMPLIES(a_fields_range, clk, rst, m_axis_tvalid && m_axis_tuser, out_in_range)
  // an empty input stage always takes a word
  `UTC_ASSERT_IMPLIES(a_bubble_ready, clk, rst, !ctl.vld[utc_pkg::ST_IN], s_axis_tready)
  // a word taken at the input is held or moved on, never dropped
  `UTC_ASSERT_NEXT(a_in_kept, clk, rst, s_axis_tvalid && s_axis_tready, ctl.vld[utc_pkg::ST_IN])

endmodule

`default_nettype wire
